// ===== design/rmr_pkg.sv =====
package rmr_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int RES_BITS    = COUNT_BITS + 1;
  localparam int ACC_BITS    = COUNT_BITS + 2;
  localparam int MACC_BITS   = SAMPLE_BITS + 2;
  localparam int STEP_BITS   = $clog2(SAMPLE_BITS);

  // Stream widths, padded to whole bytes
  localparam int IN_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_USED  = SAMPLE_BITS + RES_BITS + SAMPLE_BITS + 3 + COUNT_BITS;
  localparam int OUT_BITS  = ((OUT_USED + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0]  CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] MEAN_MAX = {SAMPLE_BITS{1'b1}};
  localparam logic [STEP_BITS-1:0]   STEP_LAST = STEP_BITS'(SAMPLE_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_FIX,
    ST_CORR,
    ST_NUM,
    ST_DIV2,
    ST_DONE
  } rmr_state_t;

endpackage

// ===== design/running_mean_with_residue.sv =====
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tdata: sample[15:0]
// m_axis    out  tdata: mean, residue, rounded_mean, mismatch, overflow,
//                       count_full, sample_count, zero pad
//
// A sample is processed by one shared restoring divide step per cycle,
// 16 steps for (sample - mean)/count and 16 for (sum + count/2)/count,
// plus the fix-up states (FIX, CORR, NUM) and the output state (DONE).
// A sample arriving with the count full goes straight from idle to DONE.
// s_axis_tready is high only while idle; a held result stalls the block in
// DONE until m_axis takes it. Synchronous reset zeroes block state and flags.
module running_mean_with_residue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rmr_pkg::IN_BITS-1:0]   s_axis_tdata,  // sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // mean, residue, rounded_mean, mismatch, overflow, count_full, sample_count
  output logic [rmr_pkg::OUT_BITS-1:0]  m_axis_tdata
);
  import rmr_pkg::*;

  rmr_state_t state, state_next;

  // Block state
  logic [SAMPLE_BITS-1:0]     mean;
  logic signed [RES_BITS-1:0] residue;
  logic [COUNT_BITS-1:0]      count;
  logic [SUM_BITS-1:0]        sum;
  logic [SAMPLE_BITS-1:0]     rounded;

  // Working registers
  logic [COUNT_BITS-1:0]      rem;
  logic [SAMPLE_BITS-1:0]     dv;
  logic [STEP_BITS-1:0]       step;
  logic                       neg;
  logic                       ovf;
  logic                       full;
  logic signed [MACC_BITS-1:0] m_acc;
  logic signed [ACC_BITS-1:0]  res_acc;

  logic accept, out_free, load_out;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS:0]   diff_in;
  logic [SAMPLE_BITS:0]   abs_in;

  // Shared divide step
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   trial_sub;
  logic                  trial_ge;
  logic [COUNT_BITS-1:0] rem_step;
  logic [SAMPLE_BITS-1:0] dv_step;

  // Fix-up terms
  logic signed [MACC_BITS-1:0] q_s;
  logic signed [ACC_BITS-1:0]  r_s;
  logic signed [ACC_BITS-1:0]  n_s;
  logic [SUM_BITS-1:0]         num;

  assign sample  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign diff_in = {1'b0, sample} - {1'b0, mean};
  assign abs_in  = diff_in[SAMPLE_BITS] ? (~diff_in + 1'b1) : diff_in;

  assign trial     = {rem, dv[SAMPLE_BITS-1]};
  assign trial_sub = trial - {1'b0, count};
  assign trial_ge  = trial >= {1'b0, count};
  assign rem_step  = trial_ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  assign dv_step   = {dv[SAMPLE_BITS-2:0], trial_ge};

  assign q_s = neg ? -$signed({2'b00, dv}) : $signed({2'b00, dv});
  assign r_s = neg ? -$signed({2'b00, rem}) : $signed({2'b00, rem});
  assign n_s = $signed({2'b00, count});
  assign num = sum + SUM_BITS'(count >> 1);

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = (count == CNT_MAX) ? ST_DONE : ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (step == STEP_LAST) state_next = ST_FIX;
      end
      ST_FIX:  state_next = ST_CORR;
      ST_CORR: state_next = ST_NUM;
      ST_NUM:  state_next = ST_DIV2;
      ST_DIV2: begin
        if (step == STEP_LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      mean    <= '0;
      residue <= '0;
      count   <= '0;
      sum     <= '0;
      rounded <= '0;
      ovf     <= 1'b0;
      full    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            step <= '0;
            ovf  <= 1'b0;
            if (count == CNT_MAX) begin
              full <= 1'b1;
            end else begin
              full  <= 1'b0;
              count <= count + 1'b1;
              sum   <= sum + SUM_BITS'(sample);
              neg   <= diff_in[SAMPLE_BITS];
              rem   <= '0;
              dv    <= abs_in[SAMPLE_BITS-1:0];
            end
          end
        end
        ST_DIV1, ST_DIV2: begin
          rem  <= rem_step;
          dv   <= dv_step;
          step <= step + 1'b1;
          if (state == ST_DIV2 && step == STEP_LAST) rounded <= dv_step;
        end
        ST_FIX: begin
          // Apply the signed quotient and remainder
          m_acc   <= $signed({2'b00, mean}) + q_s;
          res_acc <= ACC_BITS'(residue) + r_s;
        end
        ST_CORR: begin
          // Step the mean once the residue reaches plus or minus the count
          if (res_acc >= n_s) begin
            m_acc   <= m_acc + MACC_BITS'(1);
            residue <= RES_BITS'(res_acc - n_s);
          end else if (res_acc <= -n_s) begin
            m_acc   <= m_acc - MACC_BITS'(1);
            residue <= RES_BITS'(res_acc + n_s);
          end else begin
            residue <= RES_BITS'(res_acc);
          end
        end
        ST_NUM: begin
          // Saturate the mean and load the rounded-mean division
          if (m_acc < 0) begin
            mean <= '0;
            ovf  <= 1'b1;
          end else if (m_acc > $signed({2'b00, MEAN_MAX})) begin
            mean <= MEAN_MAX;
            ovf  <= 1'b1;
          end else begin
            mean <= m_acc[SAMPLE_BITS-1:0];
          end
          rem  <= num[SUM_BITS-1:SAMPLE_BITS];
          dv   <= num[SAMPLE_BITS-1:0];
          step <= '0;
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= OUT_BITS'({count, full, ovf, (mean != rounded),
                                  rounded, residue, mean});
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule
